@@ rtl/psq_pkg.sv @@
// ============================================================================
// psq_pkg
// Shared constants, types and tables for the periodic squat trajectory core.
// ============================================================================
package psq_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int MOD_STAGES    = 32;
    localparam int DIV_STEPS     = 33;
    localparam int SETUP_CYCLES  = DIV_STEPS + 4;
    localparam int XW            = 34;

    localparam logic [1:0] REG_STAND  = 2'd0;
    localparam logic [1:0] REG_CROUCH = 2'd1;
    localparam logic [1:0] REG_FREQ   = 2'd2;
    localparam logic [1:0] REG_PAUSE  = 2'd3;

    localparam logic [15:0] STAND_RST  = 16'd23173;
    localparam logic [15:0] CROUCH_RST = 16'd13107;
    localparam logic [24:0] FREQ_RST   = 25'd65536;
    localparam logic [24:0] PAUSE_RST  = 25'd98304;

    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [22:0]   PI_Q20   = 23'sd3294199;

    typedef struct packed {
        logic               busy;
        logic [15:0]        stand;
        logic signed [16:0] dr;
        logic [24:0]        freq;
        logic [24:0]        pause;
        logic [32:0]        period;
        logic signed [45:0] vel_gain;
    } psq_cfg_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41721;
            15: r = 32'd20860;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2607;
            19: r = 32'd1303;
            20: r = 32'd651;
            21: r = 32'd325;
            22: r = 32'd162;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/psq_cfg.sv @@
// ============================================================================
// psq_cfg
// Register file and setup sequencer: squat duration by serial division,
// cycle period and velocity gain.
// ============================================================================
module psq_cfg
    import psq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [31:0] wr_data,
    output psq_cfg_t    cfg
);

    logic [15:0]        stand_reg, crouch_reg;
    logic [24:0]        freq_reg, pause_reg;
    logic               busy_reg;
    logic [5:0]         cnt_reg;
    logic [24:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [32:0]        period_reg;
    logic signed [16:0] dr_reg;
    logic signed [42:0] prod_reg;
    logic signed [45:0] gain_reg;

    logic [25:0]        rem_sh;
    logic               rem_ge;
    logic [32:0]        dur;
    logic signed [65:0] gain_full;

    assign rem_sh    = {rem_reg, (cnt_reg == 6'd0)};
    assign rem_ge    = rem_sh >= {1'b0, freq_reg};
    assign dur       = (freq_reg == 25'd0) ? {1'b1, 32'd0} : quo_reg;
    assign gain_full = prod_reg * PI_Q20;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stand_reg  <= STAND_RST;
            crouch_reg <= CROUCH_RST;
            freq_reg   <= FREQ_RST;
            pause_reg  <= PAUSE_RST;
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
            rem_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                {6'd0, REG_STAND}:  stand_reg  <= wr_data[15:0];
                {6'd0, REG_CROUCH}: crouch_reg <= wr_data[15:0];
                {6'd0, REG_FREQ}:   freq_reg   <= wr_data[24:0];
                {6'd0, REG_PAUSE}:  pause_reg  <= wr_data[24:0];
                default: ;
            endcase
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 6'(DIV_STEPS))
                rem_reg <= rem_ge ? 25'(rem_sh - {1'b0, freq_reg}) : rem_sh[24:0];
            if (cnt_reg == 6'(SETUP_CYCLES))
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && cnt_reg < 6'(DIV_STEPS))
            quo_reg <= {quo_reg[31:0], rem_ge};
        period_reg <= dur + {8'd0, pause_reg};
        dr_reg     <= $signed({1'b0, stand_reg}) - $signed({1'b0, crouch_reg});
        prod_reg   <= dr_reg * $signed({1'b0, freq_reg});
        gain_reg   <= gain_full[65:20];
    end

    assign cfg.busy     = busy_reg;
    assign cfg.stand    = stand_reg;
    assign cfg.dr       = dr_reg;
    assign cfg.freq     = freq_reg;
    assign cfg.pause    = pause_reg;
    assign cfg.period   = period_reg;
    assign cfg.vel_gain = gain_reg;

endmodule

@@ rtl/psq_mod_cell.sv @@
// ============================================================================
// psq_mod_cell
// One restoring step of the time-modulo-period chain.
// ============================================================================
module psq_mod_cell
    import psq_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] divisor,
    input  logic [31:0] rem_in,
    output logic [31:0] rem_out
);

    logic [31:0] rem_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if ({32'd0, rem_in} >= divisor)
                rem_reg <= rem_in - divisor[31:0];
            else
                rem_reg <= rem_in;
        end
    end

    assign rem_out = rem_reg;

endmodule

@@ rtl/psq_cordic_cell.sv @@
// ============================================================================
// psq_cordic_cell
// One CORDIC rotation micro-step, angle in turns; carries two tag bits.
// ============================================================================
module psq_cordic_cell
    import psq_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [4:0]           shift,
    input  logic [31:0]          angle,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [XW-1:0] z_in,
    input  logic [1:0]           tag_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [XW-1:0] z_out,
    output logic [1:0]           tag_out
);

    logic signed [XW-1:0] x_reg, y_reg, z_reg;
    logic [1:0]           tag_reg;
    logic signed [XW-1:0] xs, ys, ang;

    assign xs  = x_in >>> shift;
    assign ys  = y_in >>> shift;
    assign ang = $signed({2'b00, angle});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[XW-1])
            begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - ang;
            end
            else
            begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + ang;
            end
            tag_reg <= tag_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

@@ rtl/periodic_squat_trajectory_core.sv @@
// ============================================================================
// periodic_squat_trajectory_core
// Raised-cosine squat profile: leg length and velocity from absolute time.
// ============================================================================
// Takes one time word per clock while s_tready is high and returns one
// result word per word, in order, through 32 modulo cells, pause offset,
// phase, fold, CORDIC cells and two scaling stages, then the output register.
// The pipeline stalls only when the output register is full and not taken.
// After reset and after each configuration write, s_tready stays low
// while the serial divider forms the squat duration and the period and
// velocity gain settle.
module periodic_squat_trajectory_core
    import psq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] time_s
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] length_ref, [39:16] velocity_ref
    output logic [0:0]  m_tuser    // [0] in_squat
);

    localparam int ST_CD = MOD_STAGES + 3;
    localparam int NSTG  = ST_CD + CORDIC_STAGES + 2;

    psq_cfg_t cfg;
    logic     en, acc, out_ld;
    logic [NSTG-1:0] v_reg;

    logic [31:0] rem [MOD_STAGES+1];
    logic signed [XW-1:0] cx [CORDIC_STAGES+1];
    logic signed [XW-1:0] cy [CORDIC_STAGES+1];
    logic signed [XW-1:0] cz [CORDIC_STAGES+1];
    logic [1:0]           ct [CORDIC_STAGES+1];
    logic signed [XW-1:0] c0x_reg, c0y_reg, c0z_reg;
    logic [1:0]           c0t_reg;

    logic        m1_sq_reg, m2_sq_reg;
    logic [31:0] tau_reg, u_reg;
    logic [31:0] tnorm;
    logic [56:0] u_full;
    logic [31:0] a_fold;
    logic        flip;

    logic signed [XW:0]   cf, sf, diff;
    logic signed [51:0]   p1_tmp_reg;
    logic signed [20:0]   p1_s16_reg;
    logic                 p1_sq_reg;
    logic signed [52:0]   len_sum;
    logic signed [XW:0]   s_sum;
    logic signed [22:0]   len_w;
    logic [15:0]          p2_len_reg;
    logic signed [66:0]   p2_vp_reg;
    logic                 p2_sq_reg;
    logic signed [66:0]   v_sum;
    logic signed [34:0]   v_w;
    logic signed [23:0]   v_sat;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        out_sq_reg;

    psq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;
    assign out_ld    = m_tready | ~out_valid_reg;
    assign en        = out_ld | ~v_reg[NSTG-1];
    assign s_tready  = en & ~cfg.busy;
    assign acc       = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTG-2:0], acc};
    end

    assign rem[0] = s_tdata;

    for (genvar k = 0; k < MOD_STAGES; k++)
    begin : g_mod
        logic [63:0] dk;
        assign dk = {31'd0, cfg.period} << (MOD_STAGES - 1 - k);
        psq_mod_cell u_cell (
            .clk     (clk),
            .en      (en),
            .divisor (dk),
            .rem_in  (rem[k]),
            .rem_out (rem[k+1])
        );
    end

    assign tnorm  = rem[MOD_STAGES];
    assign u_full = {32'd0, cfg.freq} * {25'd0, tau_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_sq_reg <= tnorm >= {7'd0, cfg.pause};
            tau_reg   <= tnorm - {7'd0, cfg.pause};
            m2_sq_reg <= m1_sq_reg;
            u_reg     <= u_full[31:0];
        end
    end

    assign flip   = u_reg[31] ^ u_reg[30];
    assign a_fold = flip ? (u_reg ^ 32'h8000_0000) : u_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0x_reg <= GAIN_Q30;
            c0y_reg <= '0;
            c0z_reg <= XW'($signed(a_fold));
            c0t_reg <= {m2_sq_reg, flip};
        end
    end

    assign cx[0] = c0x_reg;
    assign cy[0] = c0y_reg;
    assign cz[0] = c0z_reg;
    assign ct[0] = c0t_reg;

    for (genvar j = 0; j < CORDIC_STAGES; j++)
    begin : g_cordic
        psq_cordic_cell u_cell (
            .clk     (clk),
            .en      (en),
            .shift   (5'(j)),
            .angle   (atan_turn(j)),
            .x_in    (cx[j]),
            .y_in    (cy[j]),
            .z_in    (cz[j]),
            .tag_in  (ct[j]),
            .x_out   (cx[j+1]),
            .y_out   (cy[j+1]),
            .z_out   (cz[j+1]),
            .tag_out (ct[j+1])
        );
    end

    assign cf    = ct[CORDIC_STAGES][0] ? -(XW+1)'(cx[CORDIC_STAGES])
                                        : (XW+1)'(cx[CORDIC_STAGES]);
    assign sf    = ct[CORDIC_STAGES][0] ? -(XW+1)'(cy[CORDIC_STAGES])
                                        : (XW+1)'(cy[CORDIC_STAGES]);
    assign diff  = $signed((XW+1)'(35'sd1073741824)) - cf;
    assign s_sum = sf + 35'sd8192;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_tmp_reg <= cfg.dr * diff;
            p1_s16_reg <= 21'(s_sum >>> 14);
            p1_sq_reg  <= ct[CORDIC_STAGES][1];
        end
    end

    assign len_sum = 53'(p1_tmp_reg) + 53'sd1073741824;
    assign len_w   = $signed({7'd0, cfg.stand}) - 23'(len_sum >>> 31);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (len_w < 0)
                p2_len_reg <= '0;
            else if (len_w > 23'sd65535)
                p2_len_reg <= 16'hFFFF;
            else
                p2_len_reg <= len_w[15:0];
            p2_vp_reg <= cfg.vel_gain * p1_s16_reg;
            p2_sq_reg <= p1_sq_reg;
        end
    end

    assign v_sum = p2_vp_reg + 67'sd2147483648;
    assign v_w   = -(35'(v_sum >>> 32));
    assign v_sat = (v_w > 35'sd8388607)  ? 24'sh7FFFFF :
                   (v_w < -35'sd8388608) ? 24'sh800000 : v_w[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ld)
            out_valid_reg <= v_reg[NSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (out_ld && v_reg[NSTG-1])
        begin
            out_sq_reg <= p2_sq_reg;
            if (p2_sq_reg)
                out_data_reg <= {v_sat, p2_len_reg};
            else
                out_data_reg <= {24'd0, cfg.stand};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sq_reg;

endmodule
